@@ rtl/ssmt_pkg.sv @@
// Shared types and constants for the small set membership table.
// No dependencies; every other file uses this package.
`timescale 1ns / 1ps

package ssmt_pkg;

  // Fixed field widths of the channels
  localparam int VALUE_W  = 16;
  localparam int ACTION_W = 2;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CHANGED  = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_REFUSED  = 2'd2
  } status_t;

  // Per-cell control from the top level to one cell of the row
  typedef struct packed {
    logic occupied;  // cell index is below the fill count
    logic load_key;  // write the incoming value into this cell
    logic shift;     // delete in progress: cells at or past the hit take the upper neighbor
  } cell_ctl_t;

endpackage

@@ rtl/ssmt_if.sv @@
// Valid/ready channel interfaces for the set table input and result streams.
// Depends on ssmt_pkg for the field widths.
`timescale 1ns / 1ps

interface ssmt_in_if;
  logic                         valid;
  logic                         ready;
  logic [ssmt_pkg::ACTION_W-1:0] action;
  logic [ssmt_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface ssmt_out_if;
  logic                         valid;
  logic                         ready;
  logic                         was_member;
  logic [ssmt_pkg::COUNT_W-1:0]  count;
  logic                         is_empty;
  logic                         is_full;
  logic [ssmt_pkg::STATUS_W-1:0] status;

  modport source (output valid, output was_member, output count, output is_empty,
                  output is_full, output status, input ready);
  modport sink   (input valid, input was_member, input count, input is_empty,
                  input is_full, input status, output ready);
endinterface

@@ rtl/ssmt_cell.sv @@
// One cell of the set table row: holds one entry, compares it against the key,
// extends the hit chain and shifts down from its upper neighbor. Uses ssmt_pkg.
`timescale 1ns / 1ps

module ssmt_cell #(
  parameter int SW = 16
) (
  input  logic                  clk,
  input  ssmt_pkg::cell_ctl_t   ctl,
  input  logic [SW-1:0]         key,
  input  logic [SW-1:0]         upper_entry,
  input  logic                  hit_in,
  output logic                  hit_out,
  output logic [SW-1:0]         entry_q
);
  import ssmt_pkg::*;

  logic [SW-1:0] entry_r;
  logic [SW-1:0] entry_nxt;
  logic          match;

  assign match   = ctl.occupied && (entry_r == key);
  assign hit_out = hit_in || match;
  assign entry_q = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load_key) begin
      entry_nxt = key;
    end else if (ctl.shift && hit_out) begin
      // close the gap left by the removed entry
      entry_nxt = upper_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ rtl/small_set_membership_table_core.sv @@
// Small set membership table: top level with the cell row, fill count and result register.
// Depends on ssmt_pkg, ssmt_if and ssmt_cell.
`timescale 1ns / 1ps

// A set of up to CAPACITY distinct values kept packed in insertion order. Each
// transaction carries an action (insert, delete, query, clear) and a value; the value is
// compared against every occupied cell of the row at once, and one result follows per
// transaction with the prior membership, the count afterwards, empty/full flags and a
// status. One transaction is taken per clock cycle while ready; its result is registered
// and shows in the cycle after acceptance. The compare, hit chain and shift paths through
// the cell row are combinational. The input stays ready while the result register is
// empty or its content is being taken. Only the low VALUE_WIDTH bits of the value take
// part (at most 16). The count field carries the low five bits of the fill count.
module small_set_membership_table_core #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  ssmt_in_if.sink          in_ch,
  ssmt_out_if.source       out_ch
);
  import ssmt_pkg::*;

  localparam int SW    = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]    fill_count_r;
  logic [CNT_W-1:0]    fill_count_nxt;
  logic                out_valid_r;
  logic                was_member_r;
  logic [COUNT_W-1:0]  count_r;
  logic                is_empty_r;
  logic                is_full_r;
  status_t             status_r;
  status_t             status_nxt;

  logic                accept;
  logic                member;
  logic                full;
  logic                do_insert;
  logic                do_delete;
  action_t             action;
  logic [SW-1:0]       key;
  logic [CAPACITY:0]   hit;
  logic [SW-1:0]       entry_q [CAPACITY];
  cell_ctl_t           ctl     [CAPACITY];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign action      = action_t'(in_ch.action);
  assign key         = in_ch.value[SW-1:0];
  assign full        = (fill_count_r == CNT_W'(CAPACITY));
  assign hit[0]      = 1'b0;
  assign member      = hit[CAPACITY];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [SW-1:0] upper;
      if (gi == CAPACITY - 1) begin : g_top
        assign upper = key;
      end else begin : g_mid
        assign upper = entry_q[gi + 1];
      end

      assign ctl[gi].occupied = (CNT_W'(gi) < fill_count_r);
      assign ctl[gi].load_key = do_insert && (CNT_W'(gi) == fill_count_r);
      assign ctl[gi].shift    = do_delete;

      ssmt_cell #(.SW(SW)) u_cell (
        .clk         (clk),
        .ctl         (ctl[gi]),
        .key         (key),
        .upper_entry (upper),
        .hit_in      (hit[gi]),
        .hit_out     (hit[gi + 1]),
        .entry_q     (entry_q[gi])
      );
    end
  endgenerate

  always_comb begin
    fill_count_nxt = fill_count_r;
    status_nxt     = ST_CHANGED;
    do_insert      = 1'b0;
    do_delete      = 1'b0;
    case (action)
      ACT_INSERT: begin
        if (member) begin
          status_nxt = ST_NOCHANGE;
        end else if (full) begin
          status_nxt = ST_REFUSED;
        end else begin
          do_insert      = accept;
          fill_count_nxt = fill_count_r + CNT_W'(1);
        end
      end
      ACT_DELETE: begin
        if (!member) begin
          status_nxt = ST_NOCHANGE;
        end else begin
          do_delete      = accept;
          fill_count_nxt = fill_count_r - CNT_W'(1);
        end
      end
      ACT_QUERY: begin
        fill_count_nxt = fill_count_r;
      end
      default: begin
        fill_count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        fill_count_r <= fill_count_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // hold the result payload until a new transaction replaces it
  always_ff @(posedge clk) begin
    if (accept) begin
      was_member_r <= member;
      count_r      <= COUNT_W'(fill_count_nxt);
      is_empty_r   <= (fill_count_nxt == '0);
      is_full_r    <= (fill_count_nxt == CNT_W'(CAPACITY));
      status_r     <= status_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.was_member = was_member_r;
  assign out_ch.count      = count_r;
  assign out_ch.is_empty   = is_empty_r;
  assign out_ch.is_full    = is_full_r;
  assign out_ch.status     = status_r;

endmodule

@@ rtl/ssmt_checker.sv @@
// Port-level checks for the small set membership table, bound to the top level.
// Depends on ssmt_pkg and small_set_membership_table_core.
`timescale 1ns / 1ps

module ssmt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_was_member,
  input logic [ssmt_pkg::COUNT_W-1:0]  out_count,
  input logic                          out_is_empty,
  input logic                          out_is_full,
  input logic [ssmt_pkg::STATUS_W-1:0] out_status
);
  import ssmt_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_status))
    else $error("result changed while stalled");

  // every accepted transaction yields a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction produced no result");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_count == '0) && !out_is_full)
    else $error("empty flag disagrees with count");

  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_REFUSED) |-> out_is_full && !out_was_member)
    else $error("refusal without a full set or with a member value");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_CHANGED) || (out_status == ST_NOCHANGE)
                  || (out_status == ST_REFUSED))
    else $error("undefined status code");

endmodule

bind small_set_membership_table_core ssmt_checker u_ssmt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_was_member (out_ch.was_member),
  .out_count      (out_ch.count),
  .out_is_empty   (out_ch.is_empty),
  .out_is_full    (out_ch.is_full),
  .out_status     (out_ch.status)
);
